>>> design/skeleton_forward_kinematics_defines.svh
// Assertion macros for the skeleton forward kinematics block
`ifndef SKELETON_FORWARD_KINEMATICS_DEFINES_SVH
`define SKELETON_FORWARD_KINEMATICS_DEFINES_SVH
// Implication checked on every rising clock edge outside reset
`define SFK_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked on every rising clock edge outside reset
`define SFK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> design/sfk_pkg.sv
// Shared types and constants for the skeleton forward kinematics block
package sfk_pkg;
  localparam int PosW = 32;
  localparam int RotW = 16;
  localparam int IdxW = 8;
  localparam int CntW = 9;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_MAT, ST_MUL, ST_SUM, ST_OUT
  } sfk_state_t;

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] z;
    logic signed [RotW-1:0] qw;
    logic signed [RotW-1:0] qx;
    logic signed [RotW-1:0] qy;
    logic signed [RotW-1:0] qz;
  } pose_t;

  typedef struct packed {
    logic [IdxW-1:0] joint_index;
    logic            is_root;
    logic [IdxW-1:0] parent_index;
    logic signed [PosW-1:0] local_x;
    logic signed [PosW-1:0] local_y;
    logic signed [PosW-1:0] local_z;
    logic signed [RotW-1:0] local_qw;
    logic signed [RotW-1:0] local_qx;
    logic signed [RotW-1:0] local_qy;
    logic signed [RotW-1:0] local_qz;
  } joint_in_t;

  typedef struct packed {
    pose_t pose;
    logic  bad_order;
  } joint_out_t;

  // round half up of a 68-bit value by k bits
  function automatic logic signed [67:0] rnd68(input logic signed [67:0] v, input int k);
    logic signed [67:0] y;
    y = v + (68'sd1 <<< (k - 1));
    return y >>> k;
  endfunction
endpackage

>>> design/sfk_if.sv
// Valid/ready channel interfaces for joint transactions
interface sfk_in_if (input logic clk);
  logic valid;
  logic ready;
  sfk_pkg::joint_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sfk_out_if (input logic clk);
  logic valid;
  logic ready;
  sfk_pkg::joint_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/skeleton_forward_kinematics.sv
// The block takes one joint at a time. A root or bad joint goes from ST_READ straight
// to the output register; a child first passes the registered read of its parent's
// pose from the pose memory and ST_MAT, ST_MUL and ST_SUM, the three arithmetic
// stages of the quaternion and rotation chain, before it is loaded in ST_OUT.
// A result waits in the output register; the next joint is taken once it goes.
// Reset clears the controller and joint_count; the pose memory is not cleared.
module skeleton_forward_kinematics #(
  parameter int MAX_JOINTS = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [sfk_pkg::CntW-1:0] cfg_wdata,
  sfk_in_if.sink    joint_in,
  sfk_out_if.source joint_out
);
  import sfk_pkg::*;
  `include "skeleton_forward_kinematics_defines.svh"

  localparam int AddrW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  sfk_state_t state, state_next;
  logic [CntW-1:0] joint_count;
  joint_in_t item;
  logic bad, fits;
  pose_t parent, child, wpose;
  logic we;
  logic out_valid;
  joint_out_t out_data;

  logic in_fire;
  assign in_fire = joint_in.valid && joint_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      joint_count <= '0;
    end else if (cfg_we) begin
      joint_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item <= joint_in.data;
    end
  end

  // classify the held joint
  always_comb begin
    fits = (32'(item.joint_index) < 32'(MAX_JOINTS));
    bad  = (9'(item.joint_index) >= joint_count) || !fits ||
           (!item.is_root && item.parent_index >= item.joint_index);
  end

  sfk_pose_ram #(.Depth(MAX_JOINTS), .AddrW(AddrW)) u_ram (
    .clk(clk), .we(we), .waddr(AddrW'(item.joint_index)), .wdata(wpose),
    .raddr(AddrW'(item.parent_index)), .rdata(parent)
  );

  sfk_datapath u_dp (
    .clk(clk), .state(state), .parent(parent), .item(item), .child(child)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_fire) state_next = ST_READ;
      ST_READ: state_next = (bad || item.is_root) ? ST_OUT : ST_MAT;
      ST_MAT:  state_next = ST_MUL;
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_OUT;
      ST_OUT:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pick the pose to store and emit
  always_comb begin
    we = 1'b0;
    wpose = child;
    if (state == ST_READ && (bad || item.is_root)) begin
      wpose = '{x: item.local_x, y: item.local_y, z: item.local_z,
                qw: item.local_qw, qx: item.local_qx, qy: item.local_qy,
                qz: item.local_qz};
      we = fits;
    end else if (state == ST_OUT && !(bad || item.is_root)) begin
      we = 1'b1;
    end
  end

  logic load;
  assign load = (state == ST_READ && (bad || item.is_root)) ||
                (state == ST_OUT && !(bad || item.is_root));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (joint_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= '{pose: wpose, bad_order: bad};
    end
  end

  // hold new transactions until the last result has left
  assign joint_in.ready = (state == ST_IDLE) && !out_valid;
  assign joint_out.valid = out_valid;
  assign joint_out.data = out_data;

  `SFK_ASSERT_IMPL(a_ready_idle, joint_in.ready, state == ST_IDLE, "ready outside idle")
  `SFK_ASSERT_NEXT(a_accept_read, in_fire, state == ST_READ, "accept did not start read")
  `SFK_ASSERT_IMPL(a_load_free, load, !out_valid, "result overwritten")
endmodule

>>> design/sfk_pose_ram.sv
// Pose table: one synchronous memory with a registered read port
module sfk_pose_ram #(
  parameter int Depth = 256,
  parameter int AddrW = 8
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AddrW-1:0]    waddr,
  input  sfk_pkg::pose_t      wdata,
  input  logic [AddrW-1:0]    raddr,
  output sfk_pkg::pose_t      rdata
);
  import sfk_pkg::*;
  pose_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/sfk_datapath.sv
// Arithmetic: rotation matrix, vector rotate, Hamilton product over stages
module sfk_datapath (
  input  logic              clk,
  input  sfk_pkg::sfk_state_t state,
  input  sfk_pkg::pose_t    parent,
  input  sfk_pkg::joint_in_t item,
  output sfk_pkg::pose_t    child
);
  import sfk_pkg::*;

  logic signed [31:0] pp [4][4];
  logic signed [29:0] m [9];
  logic signed [61:0] pr [9];
  logic signed [31:0] hp [16];
  logic signed [RotW-1:0] aw, ax, ay, az, bw, bx, by, bz;
  logic signed [67:0] sx, sy, sz;
  logic signed [67:0] hw, hx, hy, hz;

  assign aw = parent.qw;
  assign ax = parent.qx;
  assign ay = parent.qy;
  assign az = parent.qz;
  assign bw = item.local_qw;
  assign bx = item.local_qx;
  assign by = item.local_qy;
  assign bz = item.local_qz;

  function automatic logic signed [RotW-1:0] sat16(input logic signed [67:0] v);
    logic signed [67:0] r;
    r = rnd68(v, 14);
    if (r > 68'sd32767) return 16'sh7fff;
    if (r < -68'sd32768) return 16'sh8000;
    return r[RotW-1:0];
  endfunction

  // matrix terms reach 2^28 in magnitude, so keep 30 bits
  function automatic logic signed [29:0] mrnd(input logic signed [35:0] v);
    logic signed [67:0] r;
    r = rnd68(68'(v), 4);
    return r[29:0];
  endfunction

  function automatic logic signed [67:0] p28(input logic signed [31:0] v);
    return 68'(v);
  endfunction

  always_ff @(posedge clk) begin
    unique case (state)
      ST_MAT: begin
        pp[0][0] <= aw * aw; pp[0][1] <= aw * ax; pp[0][2] <= aw * ay;
        pp[0][3] <= aw * az; pp[1][1] <= ax * ax; pp[1][2] <= ax * ay;
        pp[1][3] <= ax * az; pp[2][2] <= ay * ay; pp[2][3] <= ay * az;
        pp[3][3] <= az * az;
        pp[1][0] <= '0; pp[2][0] <= '0; pp[2][1] <= '0;
        pp[3][0] <= '0; pp[3][1] <= '0; pp[3][2] <= '0;
        hp[0] <= aw * bw; hp[1] <= ax * bx; hp[2] <= ay * by; hp[3] <= az * bz;
        hp[4] <= ax * bw; hp[5] <= aw * bx; hp[6] <= ay * bz; hp[7] <= az * by;
        hp[8] <= ay * bw; hp[9] <= aw * by; hp[10] <= az * bx; hp[11] <= ax * bz;
        hp[12] <= az * bw; hp[13] <= aw * bz; hp[14] <= ax * by; hp[15] <= ay * bx;
      end
      ST_MUL: begin
        m[0] <= mrnd(36'(pp[1][1]) + 36'(pp[0][0]) - 36'(pp[2][2]) - 36'(pp[3][3]));
        m[1] <= mrnd(2 * 36'(pp[1][2]) - 2 * 36'(pp[0][3]));
        m[2] <= mrnd(2 * 36'(pp[1][3]) + 2 * 36'(pp[0][2]));
        m[3] <= mrnd(2 * 36'(pp[0][3]) + 2 * 36'(pp[1][2]));
        m[4] <= mrnd(36'(pp[0][0]) - 36'(pp[1][1]) + 36'(pp[2][2]) - 36'(pp[3][3]));
        m[5] <= mrnd(2 * 36'(pp[2][3]) - 2 * 36'(pp[0][1]));
        m[6] <= mrnd(2 * 36'(pp[1][3]) - 2 * 36'(pp[0][2]));
        m[7] <= mrnd(2 * 36'(pp[0][1]) + 2 * 36'(pp[2][3]));
        m[8] <= mrnd(36'(pp[0][0]) - 36'(pp[1][1]) - 36'(pp[2][2]) + 36'(pp[3][3]));
      end
      ST_SUM: begin
        pr[0] <= item.local_x * m[0]; pr[1] <= item.local_y * m[1];
        pr[2] <= item.local_z * m[2]; pr[3] <= item.local_x * m[3];
        pr[4] <= item.local_y * m[4]; pr[5] <= item.local_z * m[5];
        pr[6] <= item.local_x * m[6]; pr[7] <= item.local_y * m[7];
        pr[8] <= item.local_z * m[8];
      end
      default: ;
    endcase
  end

  function automatic logic signed [31:0] satp(input logic signed [67:0] s,
                                              input logic signed [31:0] base);
    logic signed [67:0] r;
    r = rnd68(s, 24) + 68'(base);
    if (r > 68'sd2147483647) return 32'h7fffffff;
    if (r < -68'sd2147483648) return 32'h80000000;
    return r[31:0];
  endfunction

  always_comb begin
    sx = 68'(pr[0]) + 68'(pr[1]) + 68'(pr[2]);
    sy = 68'(pr[3]) + 68'(pr[4]) + 68'(pr[5]);
    sz = 68'(pr[6]) + 68'(pr[7]) + 68'(pr[8]);
    hw = p28(hp[0]) - p28(hp[1]) - p28(hp[2]) - p28(hp[3]);
    hx = p28(hp[4]) + p28(hp[5]) + p28(hp[6]) - p28(hp[7]);
    hy = p28(hp[8]) + p28(hp[9]) + p28(hp[10]) - p28(hp[11]);
    hz = p28(hp[12]) + p28(hp[13]) + p28(hp[14]) - p28(hp[15]);
    child.x  = satp(sx, parent.x);
    child.y  = satp(sy, parent.y);
    child.z  = satp(sz, parent.z);
    child.qw = sat16(hw);
    child.qx = sat16(hx);
    child.qy = sat16(hy);
    child.qz = sat16(hz);
  end
endmodule

>>> tb/skeleton_forward_kinematics_tb.sv
// Self-checking testbench for the skeleton forward kinematics block
`timescale 1ns / 1ps

module skeleton_forward_kinematics_tb;
  import sfk_pkg::*;

  localparam int TableDepth = 256;
  localparam int StallLimit = 5000;
  localparam int DrainCycles = 12;
  localparam int PhaseItems = 250;

  typedef struct {
    joint_in_t  joint;
    bit         typed;
    joint_out_t pose_out;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CntW-1:0] cfg_wdata = '0;

  sfk_in_if  joint_in (.clk(clk));
  sfk_out_if joint_out (.clk(clk));

  skeleton_forward_kinematics dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .joint_in(joint_in.sink), .joint_out(joint_out.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pose_t      world_table [TableDepth];
  bit         stored [TableDepth];
  int unsigned joints_in_use;
  joint_out_t pending_poses [$];
  int errors = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  int quiet_cycles = 0;
  int joints_sent = 0;
  int poses_seen = 0;
  int children_seen = 0;

  function automatic longint round_shift(longint v, int k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Work out the global pose of one joint and store it in the pose table
  function automatic joint_out_t chain_pose(joint_in_t j);
    joint_out_t r;
    longint aw, ax, ay, az, bw, bx, by, bz, lx, ly, lz;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
    pose_t par;
    bit bad;
    bad = (j.joint_index >= joints_in_use) ||
          (!j.is_root && j.parent_index >= j.joint_index);
    r.bad_order = bad;
    lx = j.local_x; ly = j.local_y; lz = j.local_z;
    bw = j.local_qw; bx = j.local_qx; by = j.local_qy; bz = j.local_qz;
    if (j.is_root || bad) begin
      r.pose = '{x: j.local_x, y: j.local_y, z: j.local_z, qw: j.local_qw,
                 qx: j.local_qx, qy: j.local_qy, qz: j.local_qz};
    end else begin
      par = world_table[j.parent_index];
      aw = par.qw; ax = par.qx; ay = par.qy; az = par.qz;
      m00 = round_shift(ax*ax + aw*aw - ay*ay - az*az, 4);
      m01 = round_shift(2*(ax*ay) - 2*(aw*az), 4);
      m02 = round_shift(2*(ax*az) + 2*(aw*ay), 4);
      m10 = round_shift(2*(aw*az) + 2*(ax*ay), 4);
      m11 = round_shift(aw*aw - ax*ax + ay*ay - az*az, 4);
      m12 = round_shift(2*(ay*az) - 2*(aw*ax), 4);
      m20 = round_shift(2*(ax*az) - 2*(aw*ay), 4);
      m21 = round_shift(2*(aw*ax) + 2*(ay*az), 4);
      m22 = round_shift(aw*aw - ax*ax - ay*ay + az*az, 4);
      r.pose.x = 32'(sat(round_shift(lx*m00 + ly*m01 + lz*m02, 24) + longint'(par.x),
                         -64'sd2147483648, 64'sd2147483647));
      r.pose.y = 32'(sat(round_shift(lx*m10 + ly*m11 + lz*m12, 24) + longint'(par.y),
                         -64'sd2147483648, 64'sd2147483647));
      r.pose.z = 32'(sat(round_shift(lx*m20 + ly*m21 + lz*m22, 24) + longint'(par.z),
                         -64'sd2147483648, 64'sd2147483647));
      r.pose.qx = 16'(sat(round_shift(ax*bw + aw*bx + ay*bz - az*by, 14), -32768, 32767));
      r.pose.qy = 16'(sat(round_shift(ay*bw + aw*by + az*bx - ax*bz, 14), -32768, 32767));
      r.pose.qz = 16'(sat(round_shift(az*bw + aw*bz + ax*by - ay*bx, 14), -32768, 32767));
      r.pose.qw = 16'(sat(round_shift(aw*bw - ax*bx - ay*by - az*bz, 14), -32768, 32767));
    end
    world_table[j.joint_index] = r.pose;
    stored[j.joint_index] = 1'b1;
    return r;
  endfunction

  function automatic logic signed [PosW-1:0] rand_pos();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      1: return $signed($urandom) >>> $urandom_range(16, 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [RotW-1:0] rand_rot();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      1: return 16'($urandom_range(32767) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed children of stored joints, some roots and some broken order
  function automatic joint_in_t rand_joint();
    joint_in_t j;
    int unsigned p;
    j.local_x = rand_pos(); j.local_y = rand_pos(); j.local_z = rand_pos();
    j.local_qw = rand_rot(); j.local_qx = rand_rot();
    j.local_qy = rand_rot(); j.local_qz = rand_rot();
    if (joints_in_use > 0 && $urandom_range(99) < 85)
      j.joint_index = 8'($urandom_range(joints_in_use - 1));
    else
      j.joint_index = 8'($urandom);
    j.parent_index = 8'($urandom);
    j.is_root = 1'b1;
    case ($urandom_range(9))
      0: j.is_root = 1'b1;
      1: begin
        j.is_root = 1'b0;
        j.parent_index = 8'($urandom_range(255, j.joint_index));
      end
      default: begin
        for (int t = 0; t < 8 && j.joint_index > 0; t++) begin
          p = $urandom_range(j.joint_index - 1);
          if (stored[p]) begin
            j.is_root = 1'b0;
            j.parent_index = 8'(p);
            break;
          end
        end
      end
    endcase
    return j;
  endfunction

  task automatic send_joint(joint_in_t j, bit typed, joint_out_t pose_out);
    joint_out_t predicted;
    while ($urandom_range(99) < tx_idle) begin
      joint_in.valid <= 1'b0;
      @(posedge clk);
    end
    joint_in.valid <= 1'b1;
    joint_in.data <= j;
    do @(posedge clk); while (!joint_in.ready);
    predicted = chain_pose(j);
    pending_poses.push_back(typed ? pose_out : predicted);
    joints_sent++;
  endtask

  task automatic set_joint_count(int unsigned n);
    joint_in.valid <= 1'b0;
    wait (pending_poses.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CntW'(n);
    @(posedge clk);
    cfg_we <= 1'b0;
    joints_in_use = n;
  endtask

  function automatic stim_row_t typed_row(joint_in_t j, bit bad);
    stim_row_t s;
    s.joint = j;
    s.typed = 1'b1;
    s.pose_out.pose = '{x: j.local_x, y: j.local_y, z: j.local_z, qw: j.local_qw,
                        qx: j.local_qx, qy: j.local_qy, qz: j.local_qz};
    s.pose_out.bad_order = bad;
    return s;
  endfunction

  function automatic stim_row_t predicted_row(joint_in_t j);
    stim_row_t s;
    s.joint = j;
    s.typed = 1'b0;
    s.pose_out = '0;
    return s;
  endfunction

  // Check each pose transaction and drive ready
  always @(posedge clk) begin
    joint_out_t got, want;
    if (rst) begin
      joint_out.ready <= 1'b0;
    end else begin
      if ((joint_in.valid && joint_in.ready) || (joint_out.valid && joint_out.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
      if (joint_out.valid && joint_out.ready) begin
        got = joint_out.data;
        poses_seen++;
        if (pending_poses.size() == 0) begin
          $error("pose transaction with nothing outstanding");
          errors++;
        end else begin
          want = pending_poses.pop_front();
          if (!want.bad_order) children_seen++;
          if (got.pose.x !== want.pose.x) begin
            $error("world_x expected %0d got %0d", want.pose.x, got.pose.x); errors++;
          end
          if (got.pose.y !== want.pose.y) begin
            $error("world_y expected %0d got %0d", want.pose.y, got.pose.y); errors++;
          end
          if (got.pose.z !== want.pose.z) begin
            $error("world_z expected %0d got %0d", want.pose.z, got.pose.z); errors++;
          end
          if (got.pose.qw !== want.pose.qw) begin
            $error("world_qw expected %0d got %0d", want.pose.qw, got.pose.qw); errors++;
          end
          if (got.pose.qx !== want.pose.qx) begin
            $error("world_qx expected %0d got %0d", want.pose.qx, got.pose.qx); errors++;
          end
          if (got.pose.qy !== want.pose.qy) begin
            $error("world_qy expected %0d got %0d", want.pose.qy, got.pose.qy); errors++;
          end
          if (got.pose.qz !== want.pose.qz) begin
            $error("world_qz expected %0d got %0d", want.pose.qz, got.pose.qz); errors++;
          end
          if (got.bad_order !== want.bad_order) begin
            $error("bad_order expected %0d got %0d", want.bad_order, got.bad_order);
            errors++;
          end
        end
      end
      joint_out.ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t solo;
    joint_in_t j;
    int unsigned counts [6] = '{256, 0, 1, 37, 200, 256};
    joints_in_use = 0;
    joint_in.valid <= 1'b0;
    joint_in.data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_joint_count(256);
    // roots at the extremes, then children, broken order and joints at the top indices
    j = '{joint_index: 0, is_root: 1, parent_index: 8'hff, local_x: 32'sh7fffffff,
          local_y: 32'sh7fffffff, local_z: 32'sh7fffffff, local_qw: 16'sh7fff,
          local_qx: 16'sh7fff, local_qy: 16'sh7fff, local_qz: 16'sh7fff};
    rows.push_back(typed_row(j, 1'b0));
    j = '{joint_index: 1, is_root: 1, parent_index: 0, local_x: 32'sh80000000,
          local_y: 32'sh80000000, local_z: 32'sh80000000, local_qw: 16'sh8000,
          local_qx: 16'sh8000, local_qy: 16'sh8000, local_qz: 16'sh8000};
    rows.push_back(typed_row(j, 1'b0));
    j = '{joint_index: 2, is_root: 0, parent_index: 0, local_x: 32'sh7fffffff,
          local_y: 32'sh7fffffff, local_z: 32'sh7fffffff, local_qw: 16'sh7fff,
          local_qx: 16'sh7fff, local_qy: 16'sh7fff, local_qz: 16'sh7fff};
    rows.push_back(predicted_row(j));
    j = '{joint_index: 3, is_root: 0, parent_index: 1, local_x: 32'sh80000000,
          local_y: 32'sh80000000, local_z: 32'sh80000000, local_qw: 16'sh8000,
          local_qx: 16'sh8000, local_qy: 16'sh8000, local_qz: 16'sh8000};
    rows.push_back(predicted_row(j));
    j = '{joint_index: 4, is_root: 1, parent_index: 0, local_x: 32'sh00010000,
          local_y: 32'sh00020000, local_z: 32'sh00030000, local_qw: 16'sd16384,
          local_qx: 0, local_qy: 0, local_qz: 0};
    rows.push_back(typed_row(j, 1'b0));
    j = '{joint_index: 5, is_root: 0, parent_index: 4, local_x: 32'sh00010000,
          local_y: 0, local_z: 0, local_qw: 16'sd11585, local_qx: 0,
          local_qy: 0, local_qz: 16'sd11585};
    rows.push_back(predicted_row(j));
    j = '{joint_index: 6, is_root: 0, parent_index: 5, local_x: 32'sh00010000,
          local_y: 32'shffff0000, local_z: 32'sh00008000, local_qw: 16'sd11585,
          local_qx: 16'sd11585, local_qy: 0, local_qz: 0};
    rows.push_back(predicted_row(j));
    j = '{joint_index: 7, is_root: 0, parent_index: 7, local_x: 32'sh12345678,
          local_y: 32'shfedcba98, local_z: 1, local_qw: 16'sh1234,
          local_qx: -1, local_qy: 1, local_qz: 0};
    rows.push_back(typed_row(j, 1'b1));
    j = '{joint_index: 8, is_root: 0, parent_index: 8'hff, local_x: -1,
          local_y: 0, local_z: 32'sh7fffffff, local_qw: 0, local_qx: 16'sh7fff,
          local_qy: 16'sh8000, local_qz: 0};
    rows.push_back(typed_row(j, 1'b1));
    j = '{joint_index: 8'hff, is_root: 1, parent_index: 8'hff, local_x: 0,
          local_y: 0, local_z: 0, local_qw: 0, local_qx: 0, local_qy: 0, local_qz: 0};
    rows.push_back(typed_row(j, 1'b0));
    j = '{joint_index: 8'hff, is_root: 0, parent_index: 2, local_x: 32'sh00040000,
          local_y: 32'sh00030000, local_z: 32'shfffc0000, local_qw: 16'sh7fff,
          local_qx: 16'sh8000, local_qy: 16'sh7fff, local_qz: 16'sh8000};
    rows.push_back(predicted_row(j));
    j = '{joint_index: 8'hfe, is_root: 0, parent_index: 8'hff, local_x: 5,
          local_y: 6, local_z: 7, local_qw: 1, local_qx: 2, local_qy: 3, local_qz: 4};
    rows.push_back(typed_row(j, 1'b1));
    foreach (rows[i]) send_joint(rows[i].joint, rows[i].typed, rows[i].pose_out);

    // count 0 forces every joint out of range; count 1 leaves only joint 0
    set_joint_count(1);
    j = rows[4].joint;
    j.joint_index = 1;
    j.is_root = 0;
    solo = typed_row(j, 1'b1);
    send_joint(j, 1'b1, solo.pose_out);

    foreach (counts[p]) begin
      set_joint_count(counts[p]);
      case (p / 2)
        0: begin tx_idle = 27; rx_idle = 71; end
        1: begin tx_idle = 71; rx_idle = 27; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      repeat (PhaseItems) send_joint(rand_joint(), 1'b0, '0);
    end

    joint_in.valid <= 1'b0;
    wait (pending_poses.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    $display("covered %0d joints and %0d poses (%0d with good order)",
             joints_sent, poses_seen, children_seen);
    $display("joint counts from 0 to 256, three idling patterns on both channels");
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
